// ===== hw/rtl/tmd_pkg.sv =====
// Shared constants, register indexes and types for the trapezoid membership block.
package tmd_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRACTION_BITS  = 15;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_EDGE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_START = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_END   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_EDGE = 2'd3;

  typedef struct packed {
    logic full;
    logic support;
  } tmd_flags_t;

endpackage

// ===== hw/rtl/tmd_front.sv =====
// Front stage: classifies the sample against the breakpoints and sets up the division.
module tmd_front #(
  parameter int SAMPLE_BITS = tmd_pkg::SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] left_edge,
  input  logic signed [SAMPLE_BITS-1:0] peak_start,
  input  logic signed [SAMPLE_BITS-1:0] peak_end,
  input  logic signed [SAMPLE_BITS-1:0] right_edge,
  output logic                          valid,
  output logic [SAMPLE_BITS-1:0]        num,
  output logic [SAMPLE_BITS-1:0]        den,
  output tmd_pkg::tmd_flags_t           flags
);

  logic signed [SAMPLE_BITS:0] t_x;
  logic signed [SAMPLE_BITS:0] le_x;
  logic signed [SAMPLE_BITS:0] ps_x;
  logic signed [SAMPLE_BITS:0] pe_x;
  logic signed [SAMPLE_BITS:0] re_x;
  logic signed [SAMPLE_BITS:0] rise_num;
  logic signed [SAMPLE_BITS:0] rise_den;
  logic signed [SAMPLE_BITS:0] fall_num;
  logic signed [SAMPLE_BITS:0] fall_den;
  logic [SAMPLE_BITS-1:0]      num_next;
  logic [SAMPLE_BITS-1:0]      den_next;
  tmd_pkg::tmd_flags_t         flags_next;

  assign t_x  = {sample[SAMPLE_BITS-1], sample};
  assign le_x = {left_edge[SAMPLE_BITS-1], left_edge};
  assign ps_x = {peak_start[SAMPLE_BITS-1], peak_start};
  assign pe_x = {peak_end[SAMPLE_BITS-1], peak_end};
  assign re_x = {right_edge[SAMPLE_BITS-1], right_edge};

  assign rise_num = t_x - le_x;
  assign rise_den = ps_x - le_x;
  assign fall_num = re_x - t_x;
  assign fall_den = re_x - pe_x;

  always_comb begin
    num_next           = '0;
    den_next           = {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
    flags_next.full    = 1'b0;
    flags_next.support = (sample > left_edge) && (sample < right_edge);
    if (sample <= left_edge) begin
      num_next = '0;
    end else if (sample < peak_start) begin
      num_next = rise_num[SAMPLE_BITS-1:0];
      den_next = rise_den[SAMPLE_BITS-1:0];
    end else if (sample <= peak_end) begin
      flags_next.full = 1'b1;
    end else if (sample < right_edge) begin
      num_next = fall_num[SAMPLE_BITS-1:0];
      den_next = fall_den[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      num   <= num_next;
      den   <= den_next;
      flags <= flags_next;
    end
  end

endmodule

// ===== hw/rtl/tmd_cell.sv =====
// Division cell: one restoring step that yields one quotient bit per cycle while en is high.
module tmd_cell #(
  parameter int SAMPLE_BITS   = tmd_pkg::SAMPLE_BITS,
  parameter int FRACTION_BITS = tmd_pkg::FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     valid_in,
  input  logic [SAMPLE_BITS-1:0]   rem_in,
  input  logic [SAMPLE_BITS-1:0]   den_in,
  input  logic [FRACTION_BITS-1:0] quo_in,
  input  tmd_pkg::tmd_flags_t      flags_in,
  output logic                     valid,
  output logic [SAMPLE_BITS-1:0]   rem,
  output logic [SAMPLE_BITS-1:0]   den,
  output logic [FRACTION_BITS-1:0] quo,
  output tmd_pkg::tmd_flags_t      flags
);

  logic [SAMPLE_BITS:0]   rem_shift;
  logic [SAMPLE_BITS:0]   rem_diff;
  logic                   take;
  logic [SAMPLE_BITS-1:0] rem_next;

  assign rem_shift = {rem_in, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, den_in};
  assign take      = rem_shift >= {1'b0, den_in};
  assign rem_next  = take ? rem_diff[SAMPLE_BITS-1:0] : rem_shift[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      rem   <= rem_next;
      den   <= den_in;
      quo   <= {quo_in[FRACTION_BITS-2:0], take};
      flags <= flags_in;
    end
  end

endmodule

// ===== hw/rtl/trapezoid_membership_degree_top.sv =====
// Data path: an accepted sample is registered in the classify stage and then in each division cell in turn.
// Throughput: one sample per cycle; a chain of FRACTION_BITS division cells, one
// quotient bit per cell, follows a classify stage, and the whole chain holds on out_stall.
// Reset (rst, synchronous): clears all valid bits and sets the four breakpoints to 0.
// Top level: trapezoidal fuzzy membership degree with a pipelined divider chain.
module trapezoid_membership_degree_top #(
  parameter int SAMPLE_BITS   = tmd_pkg::SAMPLE_BITS,
  parameter int FRACTION_BITS = tmd_pkg::FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tmd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [FRACTION_BITS:0]              degree,
  output logic                                in_support
);

  logic signed [SAMPLE_BITS-1:0] left_edge;
  logic signed [SAMPLE_BITS-1:0] peak_start;
  logic signed [SAMPLE_BITS-1:0] peak_end;
  logic signed [SAMPLE_BITS-1:0] right_edge;
  logic                          en;

  logic                     chain_valid [0:FRACTION_BITS];
  logic [SAMPLE_BITS-1:0]   chain_rem   [0:FRACTION_BITS];
  logic [SAMPLE_BITS-1:0]   chain_den   [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] chain_quo   [0:FRACTION_BITS];
  tmd_pkg::tmd_flags_t      chain_flags [0:FRACTION_BITS];

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge  <= '0;
      peak_start <= '0;
      peak_end   <= '0;
      right_edge <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmd_pkg::REG_LEFT_EDGE:  left_edge  <= cfg_data;
        tmd_pkg::REG_PEAK_START: peak_start <= cfg_data;
        tmd_pkg::REG_PEAK_END:   peak_end   <= cfg_data;
        tmd_pkg::REG_RIGHT_EDGE: right_edge <= cfg_data;
        default: ;
      endcase
    end
  end

  tmd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .sample    (sample),
    .left_edge (left_edge),
    .peak_start(peak_start),
    .peak_end  (peak_end),
    .right_edge(right_edge),
    .valid     (chain_valid[0]),
    .num       (chain_rem[0]),
    .den       (chain_den[0]),
    .flags     (chain_flags[0])
  );

  assign chain_quo[0] = '0;

  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
    tmd_cell #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_in(chain_valid[i]),
      .rem_in  (chain_rem[i]),
      .den_in  (chain_den[i]),
      .quo_in  (chain_quo[i]),
      .flags_in(chain_flags[i]),
      .valid   (chain_valid[i+1]),
      .rem     (chain_rem[i+1]),
      .den     (chain_den[i+1]),
      .quo     (chain_quo[i+1]),
      .flags   (chain_flags[i+1])
    );
  end

  assign out_valid  = chain_valid[FRACTION_BITS];
  assign in_support = chain_flags[FRACTION_BITS].support;
  assign degree     = chain_flags[FRACTION_BITS].full ? {1'b1, {FRACTION_BITS{1'b0}}}
                                                      : {1'b0, chain_quo[FRACTION_BITS]};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the trapezoid membership degree block.
module tb;

  localparam int SAMPLE_BITS    = tmd_pkg::SAMPLE_BITS;
  localparam int FRACTION_BITS  = tmd_pkg::FRACTION_BITS;
  localparam int CFG_INDEX_BITS = tmd_pkg::CFG_INDEX_BITS;
  localparam int PIPE_LATENCY = FRACTION_BITS + 1;
  localparam int QUIET_LIMIT  = 5000;
  localparam longint FULL_DEGREE = longint'(1) << FRACTION_BITS;

  typedef struct packed {
    logic [FRACTION_BITS:0] degree;
    logic                   in_support;
  } membership_t;

  logic                             clk        = 1'b0;
  logic                             rst        = 1'b1;
  logic                             cfg_valid  = 1'b0;
  logic [CFG_INDEX_BITS-1:0]        cfg_index  = '0;
  logic [SAMPLE_BITS-1:0]           cfg_data   = '0;
  logic                             in_valid   = 1'b0;
  logic signed [SAMPLE_BITS-1:0]    sample     = '0;
  logic                             out_stall  = 1'b0;
  wire                              cfg_ready;
  wire                              in_stall;
  wire                              out_valid;
  wire [FRACTION_BITS:0]            degree;
  wire                              in_support;

  logic signed [SAMPLE_BITS-1:0] trap_left       = '0;
  logic signed [SAMPLE_BITS-1:0] trap_peak_start = '0;
  logic signed [SAMPLE_BITS-1:0] trap_peak_end   = '0;
  logic signed [SAMPLE_BITS-1:0] trap_right      = '0;

  logic signed [SAMPLE_BITS-1:0] sample_backlog[$];
  membership_t                   due_memberships[$];
  int                            draft_points[$];

  logic                          sender_busy = 1'b0;
  logic                          next_valid;
  logic signed [SAMPLE_BITS-1:0] next_sample;
  int unsigned                   send_wait = 0;
  int unsigned                   recv_wait = 0;
  int unsigned                   recv_hold = 0;
  int unsigned                   send_gap_max = 19;
  int unsigned                   recv_gap_max = 19;
  int                            quiet_cycles = 0;
  int                            samples_taken = 0;
  int                            results_seen = 0;
  int                            settings_run = 0;
  int                            errors = 0;
  membership_t                   due_now;

  trapezoid_membership_degree_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .degree     (degree),
    .in_support (in_support)
  );

  always #5 clk = ~clk;

  function automatic membership_t membership_of(logic signed [SAMPLE_BITS-1:0] t);
    membership_t m;
    longint      q;
    q = 0;
    m.in_support = (t > trap_left) && (t < trap_right);
    if (t <= trap_left) begin
      q = 0;
    end else if (t < trap_peak_start) begin
      q = ((longint'(t) - longint'(trap_left)) <<< FRACTION_BITS) /
          (longint'(trap_peak_start) - longint'(trap_left));
    end else if (t <= trap_peak_end) begin
      q = FULL_DEGREE;
    end else if (t < trap_right) begin
      q = ((longint'(trap_right) - longint'(t)) <<< FRACTION_BITS) /
          (longint'(trap_right) - longint'(trap_peak_end));
    end
    if (q > FULL_DEGREE) q = FULL_DEGREE;
    m.degree = q[FRACTION_BITS:0];
    return m;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(int v);
    int c;
    c = v;
    if (c < -32768) c = -32768;
    if (c > 32767) c = 32767;
    return c[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    int pts[4];
    int lo;
    int hi;
    pts = '{int'(trap_left), int'(trap_peak_start), int'(trap_peak_end), int'(trap_right)};
    lo = pts[0];
    hi = pts[0];
    for (int i = 1; i < 4; i++) begin
      if (pts[i] < lo) lo = pts[i];
      if (pts[i] > hi) hi = pts[i];
    end
    case ($urandom_range(9))
      0, 1: return clamp_sample(int'($urandom_range(65535)) - 32768);
      2, 3: return clamp_sample(pts[$urandom_range(3)] + int'($urandom_range(6)) - 3);
      default: begin
        lo = lo - 16;
        hi = hi + 16;
        return clamp_sample(lo + int'($urandom_range(hi - lo)));
      end
    endcase
  endfunction

  task automatic pick_breakpoints();
    int kind;
    int base;
    kind = $urandom_range(3);
    draft_points.delete();
    case (kind)
      0, 3: begin
        repeat (4) draft_points.push_back(int'($urandom_range(65535)) - 32768);
        if (kind == 0) draft_points.sort();
      end
      1: begin
        base = int'($urandom_range(65535 - 16)) - 32768;
        draft_points.push_back(base);
        repeat (3) begin
          base = base + int'($urandom_range(4));
          draft_points.push_back(base);
        end
      end
      default: begin
        repeat (3) draft_points.push_back(int'($urandom_range(65535)) - 32768);
        draft_points.sort();
        draft_points.insert(2, draft_points[1]);
      end
    endcase
  endtask

  task automatic settle();
    @(posedge clk);
    while (sample_backlog.size() != 0 || sender_busy || due_memberships.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_breakpoint(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[SAMPLE_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tmd_pkg::REG_LEFT_EDGE:  trap_left       = value[SAMPLE_BITS-1:0];
      tmd_pkg::REG_PEAK_START: trap_peak_start = value[SAMPLE_BITS-1:0];
      tmd_pkg::REG_PEAK_END:   trap_peak_end   = value[SAMPLE_BITS-1:0];
      tmd_pkg::REG_RIGHT_EDGE: trap_right      = value[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_trapezoid(input int l, input int ps, input int pe, input int r,
                                   input int unsigned send_gap, input int unsigned recv_gap);
    settle();
    write_breakpoint(tmd_pkg::REG_LEFT_EDGE, l);
    write_breakpoint(tmd_pkg::REG_PEAK_START, ps);
    write_breakpoint(tmd_pkg::REG_PEAK_END, pe);
    write_breakpoint(tmd_pkg::REG_RIGHT_EDGE, r);
    send_gap_max = send_gap;
    recv_gap_max = recv_gap;
    settings_run++;
  endtask

  task automatic push_value(input int v);
    sample_backlog.push_back(clamp_sample(v));
  endtask

  task automatic push_random(input int count);
    repeat (count) sample_backlog.push_back(draw_sample());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sender_busy = 1'b0;
      send_wait = $urandom_range(send_gap_max);
    end else begin
      next_valid = in_valid;
      next_sample = sample;
      if (in_valid && !in_stall) begin
        due_memberships.push_back(membership_of(sample));
        samples_taken++;
        next_valid = 1'b0;
        sender_busy = 1'b0;
        send_wait = $urandom_range(send_gap_max);
      end
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (sample_backlog.size() > 0) begin
          next_sample = sample_backlog.pop_front();
          next_valid = 1'b1;
          sender_busy = 1'b1;
        end
      end
      in_valid <= next_valid;
      sample <= next_sample;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_memberships.size() == 0) begin
          $display("%0t: unexpected beat, degree %0d in_support %0b", $time, degree, in_support);
          errors++;
        end else begin
          due_now = due_memberships.pop_front();
          if (degree !== due_now.degree) begin
            $display("%0t: degree expected %0d, got %0d", $time, due_now.degree, degree);
            errors++;
          end
          if (in_support !== due_now.in_support) begin
            $display("%0t: in_support expected %0b, got %0b", $time, due_now.in_support,
                     in_support);
            errors++;
          end
        end
        recv_wait = $urandom_range(recv_gap_max);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset breakpoints, all zero
    settings_run++;
    push_value(-32768);
    push_value(-1);
    push_value(0);
    push_value(1);
    push_value(32767);
    push_random(10);

    program_trapezoid(-1000, -200, 300, 2000, 19, 19);
    for (int b = 0; b < 4; b++) begin
      for (int d = -1; d <= 1; d++) begin
        case (b)
          0: sample_backlog.push_back(clamp_sample(-1000 + d));
          1: sample_backlog.push_back(clamp_sample(-200 + d));
          2: sample_backlog.push_back(clamp_sample(300 + d));
          default: sample_backlog.push_back(clamp_sample(2000 + d));
        endcase
      end
    end
    push_random(20);

    program_trapezoid(-32768, 0, 0, 32767, 0, 0);
    push_value(-32768);
    push_value(-32767);
    push_value(-1);
    push_value(0);
    push_value(1);
    push_value(32766);
    push_value(32767);
    push_random(20);

    program_trapezoid(500, -500, -1000, -32768, 19, 0);
    push_random(30);

    program_trapezoid(100, 100, 200, 200, 0, 19);
    push_random(30);

    program_trapezoid(-32768, 32767, 32767, 32767, 19, 19);
    push_random(20);

    program_trapezoid(-32768, -32768, -32768, 32767, 19, 19);
    push_random(20);

    // hold the receiver so the pipeline backs up into the input
    program_trapezoid(-32768, -16384, 16383, 32767, 0, 19);
    recv_hold = 300;
    push_random(60);

    for (int k = 0; k < 10; k++) begin
      pick_breakpoints();
      program_trapezoid(draft_points[0], draft_points[1], draft_points[2], draft_points[3],
                        ($urandom_range(2) == 0) ? 0 : 19, ($urandom_range(2) == 0) ? 0 : 19);
      push_random(25);
    end

    settle();
    $display("Ran %0d samples through %0d breakpoint settings; %0d results checked, %0d mismatches.",
             samples_taken, settings_run, results_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
